// File: rtl/rtp_source_failover_selector_top_macros.svh
// Assertion macros shared by the RTP source failover selector sources.
`ifndef RTP_SOURCE_FAILOVER_SELECTOR_TOP_MACROS_SVH
`define RTP_SOURCE_FAILOVER_SELECTOR_TOP_MACROS_SVH
`ifndef SYNTH
// Checked outside reset only.
`define RSFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define RSFS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RSFS_ASSERT(name, prop, msg)
`define RSFS_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// File: rtl/rsfs_pkg.sv
// Types, codes and constants of the RTP source failover selector.
package rsfs_pkg;

  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned LOCK_RUN_PACKETS = 2;
  localparam int unsigned RTP_MIN_SIZE = 12;
  localparam int unsigned RTCP_MIN_SIZE = 8;
  localparam int unsigned LOCK_WINDOW_MS = 1000;
  localparam int unsigned MAX_SEQ_STEP = 100;
  localparam int unsigned RTCP_TYPE_LO = 192;
  localparam int unsigned RTCP_TYPE_HI = 223;
  localparam int unsigned RTP_VERSION = 2;

  localparam int unsigned IN_DATA_W = 112;
  localparam int unsigned IN_USER_W = 4;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SILENCE_TIMEOUT = 3'd0,
    REG_VIDEO_PT        = 3'd1,
    REG_AUDIO_PT        = 3'd2,
    REG_DIRECT_EN       = 3'd3,
    REG_RELAY_EN        = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CH_VIDEO_RTP  = 2'd0,
    CH_AUDIO_RTP  = 2'd1,
    CH_VIDEO_RTCP = 2'd2,
    CH_AUDIO_RTCP = 2'd3
  } chan_e;

  typedef enum logic {
    KIND_PACKET = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  typedef enum logic {
    SRC_DIRECT = 1'b0,
    SRC_RELAY  = 1'b1
  } src_e;

  typedef enum logic [1:0] {
    SEL_NONE   = 2'd0,
    SEL_DIRECT = 2'd1,
    SEL_RELAY  = 2'd2
  } sel_e;

  typedef struct packed {
    logic [15:0] silence_timeout;
    logic [6:0]  video_pt;
    logic [6:0]  audio_pt;
    logic        direct_en;
    logic        relay_en;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    src_e        source;
    chan_e       channel;
    logic [15:0] pkt_length;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [15:0] seq_number;
    logic [31:0] stream_id;
    logic [31:0] time_ms;
  } item_t;

  typedef logic [COUNT_BITS-1:0] count_t;

  // Counters are reported as their low 32 bits, zero extended when narrower.
  function automatic logic [31:0] count_out(count_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[31:0];
  endfunction

endpackage

// File: rtl/rsfs_hdr_check.sv
// Header validation of one packet summary by channel and source enable.
module rsfs_hdr_check
  import rsfs_pkg::*;
(
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output logic  ok_o
);

  logic       ver_ok;
  logic       src_en;
  logic       rtp_len_ok;
  logic       rtcp_len_ok;
  logic [6:0] pt;
  logic       chan_ok;

  assign ver_ok      = item_i.first_byte[7:6] == 2'(RTP_VERSION);
  assign src_en      = (item_i.source == SRC_DIRECT) ? cfg_i.direct_en : cfg_i.relay_en;
  assign rtp_len_ok  = item_i.pkt_length >= 16'(RTP_MIN_SIZE);
  assign rtcp_len_ok = item_i.pkt_length >= 16'(RTCP_MIN_SIZE);
  assign pt          = item_i.second_byte[6:0];

  always_comb begin
    case (item_i.channel)
      CH_VIDEO_RTP: chan_ok = rtp_len_ok && (pt == cfg_i.video_pt);
      CH_AUDIO_RTP: chan_ok = rtp_len_ok && (pt == cfg_i.audio_pt);
      default: chan_ok = rtcp_len_ok &&
                         (item_i.second_byte >= 8'(RTCP_TYPE_LO)) &&
                         (item_i.second_byte <= 8'(RTCP_TYPE_HI));
    endcase
  end

  assign ok_o = (item_i.kind == KIND_PACKET) && ver_ok && src_en && chan_ok;

endmodule

// File: rtl/rsfs_cand.sv
// Candidate tracker of one source: counts consecutive in-order video packets.
module rsfs_cand
  import rsfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        clear_i,
  input  logic        upd_i,
  input  logic [31:0] ssrc_i,
  input  logic [15:0] seq_i,
  input  logic [31:0] now_i,
  output logic        lock_o
);

  logic [31:0] ssrc_q, ssrc_d, ssrc_e;
  logic [15:0] seq_q, seq_e;
  logic [1:0]  run_q, run_d, run_e;
  logic [31:0] time_q, time_e;
  logic [15:0] step;
  logic [31:0] age;
  logic        follows;

  // A timeout in the same beat clears the tracker before it is used.
  assign ssrc_e = clear_i ? '0 : ssrc_q;
  assign seq_e  = clear_i ? '0 : seq_q;
  assign run_e  = clear_i ? '0 : run_q;
  assign time_e = clear_i ? '0 : time_q;

  assign step = seq_i - seq_e;
  assign age  = now_i - time_e;

  assign follows = (run_e != 2'd0) && (ssrc_e == ssrc_i) &&
                   (age <= 32'(LOCK_WINDOW_MS)) &&
                   (step != 16'd0) && (step <= 16'(MAX_SEQ_STEP));

  always_comb begin
    if (follows) begin
      ssrc_d = ssrc_e;
      run_d  = (run_e < 2'd2) ? run_e + 2'd1 : run_e;
    end else begin
      ssrc_d = ssrc_i;
      run_d  = 2'd1;
    end
  end

  assign lock_o = run_d >= 2'(LOCK_RUN_PACKETS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssrc_q <= '0;
      seq_q  <= '0;
      run_q  <= '0;
      time_q <= '0;
    end else if (en_i && upd_i) begin
      ssrc_q <= ssrc_d;
      seq_q  <= seq_i;
      run_q  <= run_d;
      time_q <= now_i;
    end else if (en_i && clear_i) begin
      ssrc_q <= '0;
      seq_q  <= '0;
      run_q  <= '0;
      time_q <= '0;
    end
  end

endmodule

// File: rtl/rsfs_sat_cnt.sv
// Saturating event counter that also presents its next value.
module rsfs_sat_cnt
  import rsfs_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   inc_i,
  output count_t cnt_o,
  output count_t cnt_next_o
);

  count_t cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (inc_i && (cnt_q != '1)) begin
      cnt_d = cnt_q + count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o      = cnt_q;
  assign cnt_next_o = cnt_d;

endmodule

// File: rtl/rtp_source_failover_selector_top.sv
// RTP source failover selector: picks one of two RTP sources, direct or relay,
// and marks the packets of the chosen source for forwarding. Each input beat is a
// packet header summary or a time tick, both stamped with a millisecond time.
// A beat first drops the active source when its video has been silent longer
// than the silence timeout, then validates the header for its channel, feeds the
// per-source candidate trackers while no source is active, and locks onto the
// first source that delivers two video packets with one SSRC whose sequence
// numbers step by 1 to 100 within one second. Every input beat yields exactly
// one output beat. The block takes one beat per clock cycle while the master
// side takes results: the whole update is a single pass of compare logic between
// the input register and the result register, and the state written by one beat
// is seen by the next beat. An accepted beat waits in the input register until
// the result register is free; its result is then registered and offered on the
// master side. There is no start-up sweep; the block is ready right after reset.
// Configuration is written through a simple write port and should change only
// while no beat is in flight.
`include "rtp_source_failover_selector_top_macros.svh"

module rtp_source_failover_selector_top
  import rsfs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: pkt_length[15:0], first_byte[23:16], second_byte[31:24],
  // seq_number[47:32], stream_id[79:48], time_ms[111:80].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser from bit 0: kind[0], source[1], channel[3:2].
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: header_ok[0], forward[1], current source[3:2],
  // selected_now[4], timed_out[5], direct_count[37:6], relay_count[69:38],
  // switch_count[101:70], zero padding[103:102].
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Configuration registers.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.silence_timeout <= 16'd5000;
      cfg_q.video_pt        <= 7'd96;
      cfg_q.audio_pt        <= 7'd111;
      cfg_q.direct_en       <= 1'b1;
      cfg_q.relay_en        <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SILENCE_TIMEOUT: cfg_q.silence_timeout <= cfg_wdata_i;
        REG_VIDEO_PT:        cfg_q.video_pt        <= cfg_wdata_i[6:0];
        REG_AUDIO_PT:        cfg_q.audio_pt        <= cfg_wdata_i[6:0];
        REG_DIRECT_EN:       cfg_q.direct_en       <= cfg_wdata_i[0];
        REG_RELAY_EN:        cfg_q.relay_en        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register. The result register decides whether the stage may advance.
  logic  in_valid_q;
  item_t in_q;
  logic  out_valid_q;
  logic  out_load;
  logic  fire;

  assign out_load      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_load;
  assign s_axis_tready = !in_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.kind        <= kind_e'(s_axis_tuser[0]);
      in_q.source      <= src_e'(s_axis_tuser[1]);
      in_q.channel     <= chan_e'(s_axis_tuser[3:2]);
      in_q.pkt_length  <= s_axis_tdata[15:0];
      in_q.first_byte  <= s_axis_tdata[23:16];
      in_q.second_byte <= s_axis_tdata[31:24];
      in_q.seq_number  <= s_axis_tdata[47:32];
      in_q.stream_id   <= s_axis_tdata[79:48];
      in_q.time_ms     <= s_axis_tdata[111:80];
    end
  end

  // Selection state.
  sel_e        active_sel_q, active_sel_d, act_mid;
  logic [31:0] active_last_q, active_last_d, last_mid;
  logic [31:0] silence;
  logic        tout;
  logic        hdr_ok;
  sel_e        me;
  logic        is_video;
  logic        track_en;
  logic        lock_direct, lock_relay, lock;
  logic        sel_now;
  logic        video_hit;
  logic        fwd;

  // The silence check runs first, on every beat including ticks.
  assign silence = in_q.time_ms - active_last_q;
  assign tout    = (active_sel_q != SEL_NONE) && (silence > 32'(cfg_q.silence_timeout));
  assign act_mid = tout ? SEL_NONE : active_sel_q;
  assign last_mid = tout ? '0 : active_last_q;

  rsfs_hdr_check u_hdr_check (
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .ok_o   (hdr_ok)
  );

  assign me       = (in_q.source == SRC_RELAY) ? SEL_RELAY : SEL_DIRECT;
  assign is_video = in_q.channel == CH_VIDEO_RTP;
  // Candidate tracking only runs while no source holds the selection.
  assign track_en = hdr_ok && is_video && (act_mid == SEL_NONE);

  rsfs_cand u_cand_direct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .clear_i (tout),
    .upd_i   (track_en && (in_q.source == SRC_DIRECT)),
    .ssrc_i  (in_q.stream_id),
    .seq_i   (in_q.seq_number),
    .now_i   (in_q.time_ms),
    .lock_o  (lock_direct)
  );

  rsfs_cand u_cand_relay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .clear_i (tout),
    .upd_i   (track_en && (in_q.source == SRC_RELAY)),
    .ssrc_i  (in_q.stream_id),
    .seq_i   (in_q.seq_number),
    .now_i   (in_q.time_ms),
    .lock_o  (lock_relay)
  );

  assign lock    = (in_q.source == SRC_RELAY) ? lock_relay : lock_direct;
  assign sel_now = track_en && lock;

  assign active_sel_d = sel_now ? me : act_mid;
  // Video from the source that holds the selection refreshes its silence timer.
  assign video_hit     = hdr_ok && is_video && (active_sel_d == me);
  assign active_last_d = video_hit ? in_q.time_ms : last_mid;
  assign fwd           = hdr_ok && (active_sel_d == me);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_sel_q  <= SEL_NONE;
      active_last_q <= '0;
    end else if (fire) begin
      active_sel_q  <= active_sel_d;
      active_last_q <= active_last_d;
    end
  end

  // Saturating totals.
  count_t direct_cnt, direct_next;
  count_t relay_cnt, relay_next;
  count_t switch_cnt, switch_next;

  rsfs_sat_cnt u_cnt_direct (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (fire),
    .inc_i      (hdr_ok && (in_q.source == SRC_DIRECT)),
    .cnt_o      (direct_cnt),
    .cnt_next_o (direct_next)
  );

  rsfs_sat_cnt u_cnt_relay (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (fire),
    .inc_i      (hdr_ok && (in_q.source == SRC_RELAY)),
    .cnt_o      (relay_cnt),
    .cnt_next_o (relay_next)
  );

  rsfs_sat_cnt u_cnt_switch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (fire),
    .inc_i      (sel_now),
    .cnt_o      (switch_cnt),
    .cnt_next_o (switch_next)
  );

  // Result register. It holds a finished beat while the input register already
  // takes the next one.
  logic [OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {2'b00,
                     count_out(switch_next),
                     count_out(relay_next),
                     count_out(direct_next),
                     tout,
                     sel_now,
                     active_sel_d,
                     fwd,
                     hdr_ok};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A selection is made only by a valid packet and always leaves a source active.
  `RSFS_ASSERT(a_sel_consistent, m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[0] && (m_axis_tdata[3:2] != SEL_NONE), "selection without a valid packet or an active source")
  // Forwarded video must have refreshed the silence timer.
  `RSFS_ASSERT(a_video_refresh, fire && video_hit |=> active_last_q == $past(in_q.time_ms), "video from the selected source did not refresh the silence timer")
  // The switch total moves only on a selection.
  `RSFS_ASSERT(a_switch_only_on_sel, !(fire && sel_now) |=> switch_cnt == $past(switch_cnt), "switch total moved without a selection")
  // Totals other than the switch count never move without a beat.
  `RSFS_ASSERT(a_totals_hold, !fire |=> $stable(direct_cnt) && $stable(relay_cnt), "packet totals moved without a beat")
  // A cycle in reset leaves both pipeline stages empty.
  `RSFS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid && !in_valid_q, "pipeline not empty after reset")

endmodule
